// ===== rtl/core/shcl_pkg.sv =====
`timescale 1ns / 1ps
package shcl_pkg;

  localparam int MAX_LINE_LEN_DEFAULT = 4096;

  localparam int TYPE_W  = 4;
  localparam int START_W = 12;
  localparam int LEN_W   = 13;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int MAX_PUSH   = 3;

  // token types
  localparam logic [TYPE_W-1:0] TOK_AMP     = 4'd0;
  localparam logic [TYPE_W-1:0] TOK_SEMI    = 4'd1;
  localparam logic [TYPE_W-1:0] TOK_PIPE    = 4'd2;
  localparam logic [TYPE_W-1:0] TOK_GT      = 4'd3;
  localparam logic [TYPE_W-1:0] TOK_GTGT    = 4'd4;
  localparam logic [TYPE_W-1:0] TOK_LT      = 4'd5;
  localparam logic [TYPE_W-1:0] TOK_LPAREN  = 4'd6;
  localparam logic [TYPE_W-1:0] TOK_RPAREN  = 4'd7;
  localparam logic [TYPE_W-1:0] TOK_WORD    = 4'd8;
  localparam logic [TYPE_W-1:0] TOK_UNKNOWN = 4'd9;
  localparam logic [TYPE_W-1:0] TOK_END     = 4'd10;

  // lexer modes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_WORD   = 2'd1;
  localparam logic [1:0] MODE_QUOTED = 2'd2;
  localparam logic [1:0] MODE_GT     = 2'd3;

  // characters
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [TYPE_W-1:0]  token_type;
    logic [START_W-1:0] token_start;
    logic [LEN_W-1:0]   token_length;
    logic               last_of_run;
  } token_t;

  // records produced by one item, handed to the result queue
  typedef struct packed {
    logic [1:0]                 count;
    token_t [MAX_PUSH-1:0]      recs;
  } push_t;

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_NL);
  endfunction

  function automatic logic is_quote(input logic [7:0] c);
    return (c == CH_DQUOTE) || (c == CH_SQUOTE);
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return (c == CH_AMP) || (c == CH_SEMI) || (c == CH_PIPE) || (c == CH_GT) ||
           (c == CH_LT) || (c == CH_LPAREN) || (c == CH_RPAREN);
  endfunction

  function automatic logic [TYPE_W-1:0] op_code(input logic [7:0] c);
    logic [TYPE_W-1:0] t;
    unique case (c)
      CH_AMP:    t = TOK_AMP;
      CH_SEMI:   t = TOK_SEMI;
      CH_PIPE:   t = TOK_PIPE;
      CH_GT:     t = TOK_GT;
      CH_LT:     t = TOK_LT;
      CH_LPAREN: t = TOK_LPAREN;
      CH_RPAREN: t = TOK_RPAREN;
      default:   t = TOK_UNKNOWN;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/core/shcl_lexer.sv =====
`timescale 1ns / 1ps
module shcl_lexer #(
  parameter int MAX_LINE_LEN = shcl_pkg::MAX_LINE_LEN_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  shcl_pkg::in_item_t in_item,
  input  logic               space_ok,
  output shcl_pkg::push_t    push
);

  localparam int POS_W = $clog2(MAX_LINE_LEN + 1);
  localparam int WS_W  = $clog2(MAX_LINE_LEN);

  logic               held;
  shcl_pkg::in_item_t item_q;
  logic               step;

  logic [1:0]       mode, mode_next;
  logic             qdbl, qdbl_next;
  logic             bslash, bslash_next;
  logic [WS_W-1:0]  wstart, wstart_next;
  logic [POS_W-1:0] pos, pos_next;

  assign step     = held && space_ok;
  assign in_ready = !held || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (step) begin
      held <= 1'b0;
    end
    if (in_valid && in_ready) begin
      item_q <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= shcl_pkg::MODE_IDLE;
      qdbl   <= 1'b0;
      bslash <= 1'b0;
      wstart <= '0;
      pos    <= '0;
    end else if (step) begin
      mode   <= mode_next;
      qdbl   <= qdbl_next;
      bslash <= bslash_next;
      wstart <= wstart_next;
      pos    <= pos_next;
    end
  end

  always_comb begin
    logic [7:0]       c;
    logic             do_idle;
    logic [1:0]       n;
    logic [7:0]       q;
    logic [POS_W-1:0] ws_ext;
    c       = item_q.ch;
    do_idle = 1'b0;
    n       = 2'd0;
    q       = qdbl ? shcl_pkg::CH_DQUOTE : shcl_pkg::CH_SQUOTE;
    ws_ext  = POS_W'(wstart);
    push        = '0;
    mode_next   = mode;
    qdbl_next   = qdbl;
    bslash_next = bslash;
    wstart_next = wstart;
    pos_next    = pos;

    if (pos < POS_W'(MAX_LINE_LEN)) begin
      unique case (mode)
        shcl_pkg::MODE_WORD: begin
          if (shcl_pkg::is_sep(c) || shcl_pkg::is_op(c) || shcl_pkg::is_quote(c)) begin
            push.recs[n].token_type   = shcl_pkg::TOK_WORD;
            push.recs[n].token_start  = shcl_pkg::START_W'(wstart);
            push.recs[n].token_length = shcl_pkg::LEN_W'(pos - ws_ext);
            n = n + 2'd1;
            mode_next = shcl_pkg::MODE_IDLE;
            do_idle   = 1'b1;
          end
        end
        shcl_pkg::MODE_QUOTED: begin
          if (c == q && !bslash) begin
            push.recs[n].token_type   = shcl_pkg::TOK_WORD;
            push.recs[n].token_start  = shcl_pkg::START_W'(wstart);
            push.recs[n].token_length = shcl_pkg::LEN_W'(pos + POS_W'(1) - ws_ext);
            n = n + 2'd1;
            mode_next   = shcl_pkg::MODE_IDLE;
            bslash_next = 1'b0;
          end else begin
            bslash_next = (c == shcl_pkg::CH_BSLASH);
          end
        end
        shcl_pkg::MODE_GT: begin
          mode_next = shcl_pkg::MODE_IDLE;
          push.recs[n].token_start = shcl_pkg::START_W'(wstart);
          if (c == shcl_pkg::CH_GT) begin
            push.recs[n].token_type   = shcl_pkg::TOK_GTGT;
            push.recs[n].token_length = shcl_pkg::LEN_W'(2);
          end else begin
            push.recs[n].token_type   = shcl_pkg::TOK_GT;
            push.recs[n].token_length = shcl_pkg::LEN_W'(1);
            do_idle = 1'b1;
          end
          n = n + 2'd1;
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase

      if (do_idle) begin
        priority if (shcl_pkg::is_sep(c)) begin
          mode_next = shcl_pkg::MODE_IDLE;
        end else if (c == shcl_pkg::CH_GT) begin
          mode_next   = shcl_pkg::MODE_GT;
          wstart_next = pos[WS_W-1:0];
        end else if (shcl_pkg::is_op(c)) begin
          push.recs[n].token_type   = shcl_pkg::op_code(c);
          push.recs[n].token_start  = shcl_pkg::START_W'(pos);
          push.recs[n].token_length = shcl_pkg::LEN_W'(1);
          n = n + 2'd1;
        end else if (shcl_pkg::is_quote(c)) begin
          mode_next   = shcl_pkg::MODE_QUOTED;
          qdbl_next   = (c == shcl_pkg::CH_DQUOTE);
          bslash_next = 1'b0;
          wstart_next = pos[WS_W-1:0];
        end else begin
          mode_next   = shcl_pkg::MODE_WORD;
          wstart_next = pos[WS_W-1:0];
        end
      end
      pos_next = pos + POS_W'(1);
    end

    if (item_q.is_last) begin
      // flush whatever is open, then the end record
      if (mode_next == shcl_pkg::MODE_WORD || mode_next == shcl_pkg::MODE_QUOTED) begin
        push.recs[n].token_type   = shcl_pkg::TOK_WORD;
        push.recs[n].token_start  = shcl_pkg::START_W'(wstart_next);
        push.recs[n].token_length = shcl_pkg::LEN_W'(pos_next - POS_W'(wstart_next));
        n = n + 2'd1;
      end else if (mode_next == shcl_pkg::MODE_GT) begin
        push.recs[n].token_type   = shcl_pkg::TOK_GT;
        push.recs[n].token_start  = shcl_pkg::START_W'(wstart_next);
        push.recs[n].token_length = shcl_pkg::LEN_W'(1);
        n = n + 2'd1;
      end
      push.recs[n].token_type   = shcl_pkg::TOK_END;
      push.recs[n].token_start  = '0;
      push.recs[n].token_length = '0;
      n = n + 2'd1;
      mode_next   = shcl_pkg::MODE_IDLE;
      qdbl_next   = 1'b0;
      bslash_next = 1'b0;
      wstart_next = '0;
      pos_next    = '0;
    end

    if (n != 2'd0) begin
      push.recs[n - 2'd1].last_of_run = 1'b1;
    end
    push.count = step ? n : 2'd0;
  end

endmodule

// ===== rtl/core/shcl_fifo.sv =====
`timescale 1ns / 1ps
module shcl_fifo (
  input  logic             clk,
  input  logic             rst,
  input  shcl_pkg::push_t  push,
  output logic             space_ok,
  output logic             out_valid,
  input  logic             out_ready,
  output shcl_pkg::token_t out_item
);

  localparam int PW = shcl_pkg::FIFO_PTR_W;
  localparam int CW = shcl_pkg::FIFO_CNT_W;

  shcl_pkg::token_t mem [shcl_pkg::FIFO_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign space_ok  = (count <= CW'(shcl_pkg::FIFO_DEPTH - shcl_pkg::MAX_PUSH));
  assign out_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    for (int i = 0; i < shcl_pkg::MAX_PUSH; i++) begin
      if (2'(i) < push.count) begin
        mem[wr_ptr + PW'(i)] <= push.recs[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + CW'(push.count) - CW'(pop);
    end
  end

endmodule

// ===== rtl/core/shell_command_lexer.sv =====
`timescale 1ns / 1ps
// shell command line lexer, one character byte per item
// items are registered, then their results are written to the result queue
// throughput: one item per cycle while the result queue has room for three;
//   results leave the queue at one per cycle while out_ready is high
// reset: synchronous active-high rst empties the result queue and returns the
//   lexer to idle at line position 0
module shell_command_lexer #(
  parameter int MAX_LINE_LEN = shcl_pkg::MAX_LINE_LEN_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  shcl_pkg::in_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output shcl_pkg::token_t   out_item
);

  // records from one item all go into the queue in the same cycle
  shcl_pkg::push_t push;
  // queue has room for the worst case of three records
  logic            space_ok;

  // input register, mode state and the per-character decode
  shcl_lexer #(
    .MAX_LINE_LEN(MAX_LINE_LEN)
  ) u_lexer (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .space_ok (space_ok),
    .push     (push)
  );

  // result queue decouples bursts of records from the output handshake
  shcl_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

class token_scoreboard;
  shcl_pkg::token_t expected[$];
  int               errors;
  int               checked;
  int               lines;
  // lexer state as the block should hold it
  logic [1:0]       mode;
  bit               dquote;
  bit               escaped;
  int unsigned      tok_start;
  int unsigned      pos;

  function new();
    errors  = 0;
    checked = 0;
    lines   = 0;
    clear_line();
  endfunction

  function void clear_line();
    mode      = shcl_pkg::MODE_IDLE;
    dquote    = 0;
    escaped   = 0;
    tok_start = 0;
    pos       = 0;
  endfunction

  function int pending();
    return expected.size();
  endfunction

  function void add(logic [shcl_pkg::TYPE_W-1:0] t, int unsigned s, int unsigned l);
    shcl_pkg::token_t tk;
    tk.token_type   = t;
    tk.token_start  = shcl_pkg::START_W'(s);
    tk.token_length = shcl_pkg::LEN_W'(l);
    tk.last_of_run  = 1'b0;
    expected.push_back(tk);
  endfunction

  function bit oper_of(logic [7:0] c, output logic [shcl_pkg::TYPE_W-1:0] t);
    oper_of = 1'b1;
    case (c)
      shcl_pkg::CH_AMP:    t = shcl_pkg::TOK_AMP;
      shcl_pkg::CH_SEMI:   t = shcl_pkg::TOK_SEMI;
      shcl_pkg::CH_PIPE:   t = shcl_pkg::TOK_PIPE;
      shcl_pkg::CH_GT:     t = shcl_pkg::TOK_GT;
      shcl_pkg::CH_LT:     t = shcl_pkg::TOK_LT;
      shcl_pkg::CH_LPAREN: t = shcl_pkg::TOK_LPAREN;
      shcl_pkg::CH_RPAREN: t = shcl_pkg::TOK_RPAREN;
      default: begin
        t = shcl_pkg::TOK_UNKNOWN;
        oper_of = 1'b0;
      end
    endcase
  endfunction

  // a character seen between tokens
  function void from_idle(logic [7:0] c, int unsigned p);
    logic [shcl_pkg::TYPE_W-1:0] t;
    if (c == shcl_pkg::CH_SPACE || c == shcl_pkg::CH_NL) return;
    if (c == shcl_pkg::CH_GT) begin
      mode      = shcl_pkg::MODE_GT;
      tok_start = p;
    end else if (oper_of(c, t)) begin
      add(t, p, 1);
    end else if (c == shcl_pkg::CH_DQUOTE || c == shcl_pkg::CH_SQUOTE) begin
      mode      = shcl_pkg::MODE_QUOTED;
      dquote    = (c == shcl_pkg::CH_DQUOTE);
      escaped   = 0;
      tok_start = p;
    end else begin
      mode      = shcl_pkg::MODE_WORD;
      tok_start = p;
    end
  endfunction

  function void note_item(shcl_pkg::in_item_t it);
    logic [shcl_pkg::TYPE_W-1:0] t;
    logic [7:0]                  c;
    logic [7:0]                  q;
    int                          first;
    c     = it.ch;
    first = expected.size();
    if (pos < shcl_pkg::MAX_LINE_LEN_DEFAULT) begin
      case (mode)
        shcl_pkg::MODE_WORD: begin
          if (c == shcl_pkg::CH_SPACE || c == shcl_pkg::CH_NL || oper_of(c, t) ||
              c == shcl_pkg::CH_DQUOTE || c == shcl_pkg::CH_SQUOTE) begin
            add(shcl_pkg::TOK_WORD, tok_start, pos - tok_start);
            mode = shcl_pkg::MODE_IDLE;
            from_idle(c, pos);
          end
        end
        shcl_pkg::MODE_QUOTED: begin
          q = dquote ? shcl_pkg::CH_DQUOTE : shcl_pkg::CH_SQUOTE;
          if (c == q && !escaped) begin
            add(shcl_pkg::TOK_WORD, tok_start, pos + 1 - tok_start);
            mode    = shcl_pkg::MODE_IDLE;
            escaped = 0;
          end else begin
            escaped = (c == shcl_pkg::CH_BSLASH);
          end
        end
        shcl_pkg::MODE_GT: begin
          mode = shcl_pkg::MODE_IDLE;
          if (c == shcl_pkg::CH_GT) begin
            add(shcl_pkg::TOK_GTGT, tok_start, 2);
          end else begin
            add(shcl_pkg::TOK_GT, tok_start, 1);
            from_idle(c, pos);
          end
        end
        default: begin
          mode = shcl_pkg::MODE_IDLE;
          from_idle(c, pos);
        end
      endcase
      pos++;
    end
    if (it.is_last) begin
      if (mode == shcl_pkg::MODE_WORD || mode == shcl_pkg::MODE_QUOTED)
        add(shcl_pkg::TOK_WORD, tok_start, pos - tok_start);
      else if (mode == shcl_pkg::MODE_GT)
        add(shcl_pkg::TOK_GT, tok_start, 1);
      add(shcl_pkg::TOK_END, 0, 0);
      clear_line();
      lines++;
    end
    if (expected.size() > first)
      expected[expected.size() - 1].last_of_run = 1'b1;
  endfunction

  function void report(string what, logic [12:0] want, logic [12:0] got);
    errors++;
    $display("%0t: token %0d %s mismatch: expected %0d, got %0d",
             $time, checked, what, want, got);
  endfunction

  function void check_token(shcl_pkg::token_t got);
    shcl_pkg::token_t want;
    checked++;
    if (expected.size() == 0) begin
      errors++;
      $display("%0t: unexpected token: expected none, got type %0d start %0d len %0d",
               $time, got.token_type, got.token_start, got.token_length);
      return;
    end
    want = expected.pop_front();
    if (got.token_type !== want.token_type)
      report("type", want.token_type, got.token_type);
    if (got.token_start !== want.token_start)
      report("start", want.token_start, got.token_start);
    if (got.token_length !== want.token_length)
      report("length", want.token_length, got.token_length);
    if (got.last_of_run !== want.last_of_run)
      report("last_of_run", want.last_of_run, got.last_of_run);
  endfunction
endclass

module tb_top;

  // cycles with no item moving on either side before the run is called dead
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 90;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  shcl_pkg::in_item_t in_item = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  shcl_pkg::token_t   out_item;

  int send_idle_pct = 26;
  int recv_idle_pct = 66;
  int items_sent = 0;

  token_scoreboard sb = new();

  shell_command_lexer uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // receiver: random back-pressure, decided at the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // every token taken at a rising edge is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_token(out_item);
  end

  // watchdog: nothing accepted on either side for too long
  initial begin : watchdog
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        stall = 0;
      else
        stall++;
    end
    $display("%0t: no progress for %0d cycles, %0d tokens still due",
             $time, STALL_LIMIT, sb.pending());
    $display("tb_top: FAIL");
    $finish;
  end

  // one character item; called and returning at a falling edge
  task automatic send_char(input logic [7:0] c, input logic last);
    shcl_pkg::in_item_t it;
    it.ch      = c;
    it.is_last = last;
    // random gaps before the item, valid low meanwhile
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // accepted at this edge, so the predictor moves on
    sb.note_item(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_line(ref logic [7:0] line[$]);
    foreach (line[i])
      send_char(line[i], i == line.size() - 1);
  endtask

  function automatic logic [7:0] word_char();
    string pool = "abcdefxyz0129_-./=$*";
    if ($urandom_range(9) == 0)
      return 8'($urandom_range(128, 255));
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  // a random command line: mostly tokens with random content, some raw noise
  function automatic void make_line(ref logic [7:0] line[$]);
    logic [7:0] ops [7] = '{shcl_pkg::CH_AMP, shcl_pkg::CH_SEMI, shcl_pkg::CH_PIPE,
                            shcl_pkg::CH_LT, shcl_pkg::CH_LPAREN, shcl_pkg::CH_RPAREN,
                            shcl_pkg::CH_GT};
    logic [7:0] q;
    line.delete();
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 12)) line.push_back(8'($urandom_range(255)));
      return;
    end
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(7))
        0, 1: repeat ($urandom_range(1, 5)) line.push_back(word_char());
        2: begin
          // quoted word, escapes and the other quote inside, sometimes left open
          q = $urandom_range(1) ? shcl_pkg::CH_DQUOTE : shcl_pkg::CH_SQUOTE;
          line.push_back(q);
          repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(5))
              0: line.push_back(shcl_pkg::CH_SPACE);
              1: line.push_back(shcl_pkg::CH_NL);
              2: line.push_back(shcl_pkg::CH_BSLASH);
              3: line.push_back(q == shcl_pkg::CH_DQUOTE ? shcl_pkg::CH_SQUOTE :
                                                           shcl_pkg::CH_DQUOTE);
              4: begin
                line.push_back(shcl_pkg::CH_BSLASH);
                line.push_back(q);
              end
              default: line.push_back(word_char());
            endcase
          end
          if ($urandom_range(99) < 80) line.push_back(q);
        end
        3: line.push_back(ops[$urandom_range(6)]);
        4: repeat ($urandom_range(1, 3)) line.push_back(shcl_pkg::CH_GT);
        5: repeat ($urandom_range(1, 2))
             line.push_back($urandom_range(1) ? shcl_pkg::CH_SPACE : shcl_pkg::CH_NL);
        6: line.push_back(8'($urandom_range(255)));
        default: begin
          line.push_back(shcl_pkg::CH_GT);
          line.push_back(word_char());
        end
      endcase
      if ($urandom_range(1))
        line.push_back($urandom_range(3) ? shcl_pkg::CH_SPACE : shcl_pkg::CH_NL);
    end
  endfunction

  initial begin : stimulus
    logic [7:0] line[$];
    string      directed [4];
    int         start_count;

    // operators, >> versus >, escaped quote, escaped backslash, open quote at
    // end of line, a newline alone on a line
    directed[0] = "x&;|<()";
    directed[1] = ">>a>b>";
    directed[2] = "w\"a\\\"b\"'\\\\'";
    directed[3] = "\n";

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed lines
    foreach (directed[k]) begin
      line.delete();
      for (int i = 0; i < directed[k].len(); i++) line.push_back(directed[k][i]);
      send_line(line);
    end
    // top byte flushed as a one-char word, then zero byte closed by an operator
    send_char(8'hFF, 1'b1);
    send_char(8'h00, 1'b0);
    send_char(shcl_pkg::CH_RPAREN, 1'b1);

    // random lines under three idling patterns
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 26; recv_idle_pct = 66; end
        1: begin send_idle_pct = 66; recv_idle_pct = 26; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      start_count = items_sent;
      while (items_sent - start_count < PHASE_ITEMS) begin
        make_line(line);
        send_line(line);
      end
    end

    in_valid <= 1'b0;

    // drain predicted tokens, then wait on for any strays
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("summary: %0d items in %0d lines, %0d tokens checked, %0d mismatches",
             items_sent, sb.lines, sb.checked, sb.errors);
    $display("summary: operators, quotes with escapes, open quotes and noise bytes");
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
